// ===== rtl/affine_vertex_transform_defines.svh =====
// Assertion macros shared by the affine vertex transform checkers.
`ifndef AFFINE_VERTEX_TRANSFORM_DEFINES_SVH
`define AFFINE_VERTEX_TRANSFORM_DEFINES_SVH

// Assert a property on the rising clock edge, disabled while reset is low.
`define AVT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition never holds on a rising clock edge outside reset.
`define AVT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/avt_pkg.sv =====
// Shared constants, types and register codes of the affine vertex transform.
`timescale 1ns / 1ps
`default_nettype none

package avt_pkg;

    // Data widths
    localparam int COORD_W         = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int COEF_W          = 32;
    localparam int PROD_W          = COORD_W + COEF_W;
    localparam int TRANS_W         = COEF_W + COORD_FRAC_BITS;
    // Three products of at most 2^62 in magnitude each plus the translation fit in 66 bits
    localparam int ACC_W           = PROD_W + 2;

    localparam int COEF_FRAC_BITS_DEF = 24;

    // Configuration port
    localparam int NUM_ROWS   = 3;
    localparam int NUM_REGS   = 2 * NUM_ROWS;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0100_0000,  // m00 = 1.0
        64'h0000_0000_0000_0000,
        64'h0100_0000_0000_0000,  // m11 = 1.0
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0100_0000   // m22 = 1.0
    };

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_X_COEFS_A = 3'd0,
        REG_X_COEFS_B = 3'd1,
        REG_Y_COEFS_A = 3'd2,
        REG_Y_COEFS_B = 3'd3,
        REG_Z_COEFS_A = 3'd4,
        REG_Z_COEFS_B = 3'd5
    } t_reg_idx;

    // One matrix row: a = {m_r1, m_r0}, b = {m_r3, m_r2}
    typedef struct packed {
        logic [CFG_DATA_W-1:0] coefs_a;
        logic [CFG_DATA_W-1:0] coefs_b;
    } t_row_coefs;

    // Load enables of the lane pipeline stages
    typedef struct packed {
        logic en_mul;
        logic en_sum;
        logic en_clamp;
    } t_pipe_ctl;

endpackage

`default_nettype wire

// ===== rtl/avt_cfg.sv =====
// APB register file holding the three coefficient rows of the matrix.
`timescale 1ns / 1ps
`default_nettype none

module avt_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [avt_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [avt_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [avt_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output avt_pkg::t_row_coefs                  o_rows [avt_pkg::NUM_ROWS]
);

    logic [avt_pkg::CFG_DATA_W-1:0] r_regs [avt_pkg::NUM_REGS];
    avt_pkg::t_reg_idx              reg_idx;
    logic                           wr_en;

    // Registers sit on 8-byte boundaries
    assign reg_idx = avt_pkg::t_reg_idx'(paddr[avt_pkg::CFG_ADDR_W-1:3]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Write a register; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < avt_pkg::NUM_REGS; i++) begin
                r_regs[i] <= avt_pkg::CFG_RESET[i];
            end
        end else if (wr_en) begin
            case (reg_idx)
                avt_pkg::REG_X_COEFS_A, avt_pkg::REG_X_COEFS_B,
                avt_pkg::REG_Y_COEFS_A, avt_pkg::REG_Y_COEFS_B,
                avt_pkg::REG_Z_COEFS_A, avt_pkg::REG_Z_COEFS_B: begin
                    r_regs[reg_idx] <= pwdata;
                end
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            avt_pkg::REG_X_COEFS_A, avt_pkg::REG_X_COEFS_B,
            avt_pkg::REG_Y_COEFS_A, avt_pkg::REG_Y_COEFS_B,
            avt_pkg::REG_Z_COEFS_A, avt_pkg::REG_Z_COEFS_B: begin
                prdata = r_regs[reg_idx];
            end
            default: prdata = '0;
        endcase
    end

    // Present the registers as rows
    always_comb begin
        for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
            o_rows[r].coefs_a = r_regs[2*r];
            o_rows[r].coefs_b = r_regs[2*r+1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/avt_lane.sv =====
// One row lane: three products, exact sum, shift and clamp to Q16.16.
`timescale 1ns / 1ps
`default_nettype none

module avt_lane #(
    parameter int COEF_FRAC_BITS = avt_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire avt_pkg::t_pipe_ctl                  i_ctl,
    input  wire avt_pkg::t_row_coefs                 i_row,
    input  wire logic signed [avt_pkg::COORD_W-1:0]  i_coord_x,
    input  wire logic signed [avt_pkg::COORD_W-1:0]  i_coord_y,
    input  wire logic signed [avt_pkg::COORD_W-1:0]  i_coord_z,
    input  wire logic                                i_is_direction,
    output logic signed      [avt_pkg::COORD_W-1:0]  o_result,
    output logic                                     o_clamped
);

    localparam int CW = avt_pkg::COEF_W;
    localparam int AW = avt_pkg::ACC_W;

    logic signed [CW-1:0]                   m0, m1, m2, m3;
    logic signed [avt_pkg::PROD_W-1:0]      n_p0, n_p1, n_p2;
    logic signed [avt_pkg::PROD_W-1:0]      r_p0, r_p1, r_p2;
    logic signed [avt_pkg::TRANS_W-1:0]     n_trans, r_trans;
    logic signed [AW-1:0]                   n_acc, r_acc;
    logic signed [AW-1:0]                   shifted;
    logic [AW-avt_pkg::COORD_W:0]           upper;
    logic signed [avt_pkg::COORD_W-1:0]     n_result;
    logic                                   n_clamped;

    // Split the row into its four coefficients
    assign m0 = i_row.coefs_a[CW-1:0];
    assign m1 = i_row.coefs_a[2*CW-1:CW];
    assign m2 = i_row.coefs_b[CW-1:0];
    assign m3 = i_row.coefs_b[2*CW-1:CW];

    // Multiply; translation is m3 scaled to the coordinate format, positions only
    assign n_p0    = m0 * i_coord_x;
    assign n_p1    = m1 * i_coord_y;
    assign n_p2    = m2 * i_coord_z;
    assign n_trans = i_is_direction ? '0 : {m3, {avt_pkg::COORD_FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_trans <= n_trans;
        end
    end

    // Sum exactly
    assign n_acc = AW'(r_p0) + AW'(r_p1) + AW'(r_p2) + AW'(r_trans);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_acc <= n_acc;
        end
    end

    // Shift down to Q16.16 and clamp to 32 bits
    assign shifted = r_acc >>> COEF_FRAC_BITS;
    assign upper   = shifted[AW-1:avt_pkg::COORD_W-1];

    always_comb begin
        if ((&upper) || !(|upper)) begin
            n_result  = shifted[avt_pkg::COORD_W-1:0];
            n_clamped = 1'b0;
        end else begin
            n_result  = shifted[AW-1] ? avt_pkg::COORD_MIN : avt_pkg::COORD_MAX;
            n_clamped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_clamp) begin
            o_result  <= n_result;
            o_clamped <= n_clamped;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/affine_vertex_transform.sv =====
// Top level: three row lanes, merge into the output register, handshake control.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  vertex   | in        | i_valid / o_stall  | i_coord_x, i_coord_y, i_coord_z, i_is_direction
//  result   | out       | o_valid / i_stall  | o_out_x, o_out_y, o_out_z, o_saturated
//  config   | in        | APB, pready high   | paddr, pwdata, prdata (six 64-bit registers)
//
// One item per clock sustained while i_stall is low; the path runs through the multiplier stage,
// adder stage, shift/clamp stage, then the merge into the output register.
// Reset is synchronous and clears the stage valid bits but not the data registers; the coefficient
// registers return to the identity matrix.
// A stall collapses bubbles first: o_stall rises only when every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module affine_vertex_transform #(
    parameter int COEF_FRAC_BITS = avt_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Vertex input
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [avt_pkg::COORD_W-1:0]  i_coord_x,
    input  wire logic signed [avt_pkg::COORD_W-1:0]  i_coord_y,
    input  wire logic signed [avt_pkg::COORD_W-1:0]  i_coord_z,
    input  wire logic                                i_is_direction,
    // Result output
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed      [avt_pkg::COORD_W-1:0]  o_out_x,
    output logic signed      [avt_pkg::COORD_W-1:0]  o_out_y,
    output logic signed      [avt_pkg::COORD_W-1:0]  o_out_z,
    output logic                                     o_saturated,
    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [avt_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [avt_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [avt_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                     pready
);

    avt_pkg::t_row_coefs              rows [avt_pkg::NUM_ROWS];
    avt_pkg::t_pipe_ctl               ctl;
    logic signed [avt_pkg::COORD_W-1:0] lane_result [avt_pkg::NUM_ROWS];
    logic [avt_pkg::NUM_ROWS-1:0]     lane_clamped;

    logic r_v_mul, r_v_sum, r_v_clamp;
    logic ld_out, ld_clamp, ld_sum, ld_mul;
    logic in_accept;

    avt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rows  (rows)
    );

    // A stage loads when it is empty or its contents move on
    assign ld_out    = !o_valid || !i_stall;
    assign ld_clamp  = !r_v_clamp || ld_out;
    assign ld_sum    = !r_v_sum || ld_clamp;
    assign ld_mul    = !r_v_mul || ld_sum;
    assign o_stall   = !ld_mul;
    assign in_accept = i_valid && ld_mul;

    assign ctl.en_mul   = in_accept;
    assign ctl.en_sum   = ld_sum && r_v_mul;
    assign ctl.en_clamp = ld_clamp && r_v_sum;

    // Advance the stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul   <= 1'b0;
            r_v_sum   <= 1'b0;
            r_v_clamp <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            if (ld_mul)   r_v_mul   <= i_valid;
            if (ld_sum)   r_v_sum   <= r_v_mul;
            if (ld_clamp) r_v_clamp <= r_v_sum;
            if (ld_out)   o_valid   <= r_v_clamp;
        end
    end

    // One lane per matrix row
    for (genvar r = 0; r < avt_pkg::NUM_ROWS; r++) begin : g_lane
        avt_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk          (i_clk),
            .i_ctl          (ctl),
            .i_row          (rows[r]),
            .i_coord_x      (i_coord_x),
            .i_coord_y      (i_coord_y),
            .i_coord_z      (i_coord_z),
            .i_is_direction (i_is_direction),
            .o_result       (lane_result[r]),
            .o_clamped      (lane_clamped[r])
        );
    end

    // Merge the lanes into the output register
    always_ff @(posedge i_clk) begin
        if (ld_out && r_v_clamp) begin
            o_out_x     <= lane_result[0];
            o_out_y     <= lane_result[1];
            o_out_z     <= lane_result[2];
            o_saturated <= |lane_clamped;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/avt_checker.sv =====
// Port-level checks of the affine vertex transform, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "affine_vertex_transform_defines.svh"

module avt_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_stall,
    input wire logic                                o_valid,
    input wire logic                                i_stall,
    input wire logic signed [avt_pkg::COORD_W-1:0]  o_out_x,
    input wire logic signed [avt_pkg::COORD_W-1:0]  o_out_y,
    input wire logic signed [avt_pkg::COORD_W-1:0]  o_out_z,
    input wire logic                                o_saturated,
    input wire logic                                pready
);

    // A result waiting on a stall holds its payload
    `AVT_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_saturated), "result changed while stalled")

    // With the output register empty the pipeline always takes an item
    `AVT_NEVER(a_stall_empty, i_clk, i_rst_n, !o_valid && o_stall, "input stalled with empty output")

    // A clamp flag comes with at least one component at a rail
    `AVT_ASSERT(a_sat_rail, i_clk, i_rst_n, o_valid && o_saturated |-> o_out_x == avt_pkg::COORD_MAX || o_out_x == avt_pkg::COORD_MIN || o_out_y == avt_pkg::COORD_MAX || o_out_y == avt_pkg::COORD_MIN || o_out_z == avt_pkg::COORD_MAX || o_out_z == avt_pkg::COORD_MIN, "saturated set with no clamped component")

    // The configuration port never inserts wait states
    `AVT_NEVER(a_pready, i_clk, i_rst_n, !pready, "pready dropped")

endmodule

bind affine_vertex_transform avt_checker u_avt_checker (.*);

`default_nettype wire
